@@ rtl/lspc_pkg.sv @@
// shared types and constants for the latching solenoid pulse controller
// no dependencies; imported by every lspc module and the top level
`timescale 1ns / 1ps
`default_nettype none

package lspc_pkg;

  // request kinds carried in req_type
  localparam logic REQ_BUTTON = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // button bit positions
  localparam int BTN_OPEN_BIT  = 0;
  localparam int BTN_CLOSE_BIT = 1;

  // last value of seconds and minutes before they roll over
  localparam logic [5:0] LAST_SEC_MIN = 6'd59;

  // configuration register indexes and reset values
  localparam logic REG_PULSE_TICKS      = 1'b0;
  localparam logic REG_TICKS_PER_SECOND = 1'b1;
  localparam logic [7:0] PULSE_TICKS_RST      = 8'd10;
  localparam logic [6:0] TICKS_PER_SECOND_RST = 7'd100;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    DRV_IDLE  = 2'd0,
    DRV_CLOSE = 2'd1,
    DRV_OPEN  = 2'd2
  } drive_code_t;

  typedef struct packed {
    logic       req_type;
    logic [1:0] buttons;
  } req_beat_t;

  typedef struct packed {
    logic [1:0]  driver_code;
    logic        is_opened;
    logic        is_closed;
    logic        already_there;
    logic [31:0] drive_tick_count;
    logic [15:0] elapsed_hours;
    logic [5:0]  elapsed_minutes;
    logic [5:0]  elapsed_seconds;
  } res_beat_t;

  typedef struct packed {
    logic [15:0] hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } clock_t;

  typedef struct packed {
    drive_code_t drive;
    logic        opened;
    logic        closed;
    logic        already_there;
    logic [31:0] odometer;
  } drive_status_t;

endpackage

`default_nettype wire

@@ rtl/latching_solenoid_pulse_ctrl.sv @@
// latching solenoid pulse controller, top level: apb registers and channel glue
// depends on lspc_pkg, lspc_timekeeper, lspc_pulse_ctrl, lspc_skid
// an accepted beat's result shows on out_beat after its edge if no older result waits
// throughput: one beat per cycle; the two-entry result buffer keeps in_ready high while
//   one result waits, so a stalled output only blocks input once both entries are full
// reset: synchronous active-high rst clears clock, pulse window, flags, odometer and buffer;
//   pulse_ticks returns to 10 and ticks_per_second to 100
`timescale 1ns / 1ps
`default_nettype none

module latching_solenoid_pulse_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // request channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire lspc_pkg::req_beat_t        in_beat,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output lspc_pkg::res_beat_t             out_beat,
  // configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lspc_pkg::APB_AW-1:0] paddr,
  input  wire logic [lspc_pkg::APB_DW-1:0] pwdata,
  output logic [lspc_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import lspc_pkg::*;

  logic [7:0]    pulse_ticks;
  logic [6:0]    ticks_per_second;
  logic          cfg_write;
  logic          reg_sel;
  logic          step;
  logic          tick;
  clock_t        time_next;
  drive_status_t status_next;
  res_beat_t     result;

  // register index comes from the word address; accesses are always zero-wait
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks      <= PULSE_TICKS_RST;
      ticks_per_second <= TICKS_PER_SECOND_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_PULSE_TICKS:      pulse_ticks      <= pwdata[7:0];
        REG_TICKS_PER_SECOND: ticks_per_second <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PULSE_TICKS:      prdata = {24'd0, pulse_ticks};
      REG_TICKS_PER_SECOND: prdata = {25'd0, ticks_per_second};
      default:              prdata = '0;
    endcase
  end

  // a beat is taken whenever the result buffer has room; state updates at that edge
  assign step = in_valid && in_ready;
  assign tick = step && (in_beat.req_type == REQ_TICK);

  // elapsed time only advances on tick beats
  lspc_timekeeper u_timekeeper (
    .clk              (clk),
    .rst              (rst),
    .tick             (tick),
    .ticks_per_second (ticks_per_second),
    .time_next        (time_next)
  );

  // button beats latch requests, tick beats run the drive window
  lspc_pulse_ctrl u_pulse_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .req         (in_beat),
    .pulse_ticks (pulse_ticks),
    .status_next (status_next)
  );

  // the result reports state as it stands after this beat
  always_comb begin
    result.driver_code      = status_next.drive;
    result.is_opened        = status_next.opened;
    result.is_closed        = status_next.closed;
    result.already_there    = status_next.already_there;
    result.drive_tick_count = status_next.odometer;
    result.elapsed_hours    = time_next.hours;
    result.elapsed_minutes  = time_next.minutes;
    result.elapsed_seconds  = time_next.seconds;
  end

  // result register pair decouples the output handshake from acceptance
  lspc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_beat (result),
    .not_full  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule

`default_nettype wire

@@ rtl/lspc_timekeeper.sv @@
// elapsed hours:minutes:seconds clock advanced by tick beats
// depends on lspc_pkg
`timescale 1ns / 1ps
`default_nettype none

module lspc_timekeeper (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            tick,
  input  wire logic [6:0]      ticks_per_second,
  output lspc_pkg::clock_t     time_next
);
  import lspc_pkg::*;

  logic [6:0]  subsecond;
  logic [6:0]  subsecond_next;
  logic [5:0]  seconds;
  logic [5:0]  seconds_next;
  logic [5:0]  minutes;
  logic [5:0]  minutes_next;
  logic [15:0] hours;
  logic [15:0] hours_next;

  logic [6:0] sub_inc;
  logic       sec_roll;

  assign sub_inc  = subsecond + 7'd1;
  assign sec_roll = (sub_inc >= ticks_per_second);

  always_comb begin
    subsecond_next = subsecond;
    seconds_next   = seconds;
    minutes_next   = minutes;
    hours_next     = hours;
    if (tick) begin
      subsecond_next = sec_roll ? 7'd0 : sub_inc;
      if (sec_roll) begin
        if (seconds >= LAST_SEC_MIN) begin
          seconds_next = 6'd0;
          if (minutes >= LAST_SEC_MIN) begin
            minutes_next = 6'd0;
            hours_next   = hours + 16'd1;
          end else begin
            minutes_next = minutes + 6'd1;
          end
        end else begin
          seconds_next = seconds + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      subsecond <= '0;
      seconds   <= '0;
      minutes   <= '0;
      hours     <= '0;
    end else begin
      subsecond <= subsecond_next;
      seconds   <= seconds_next;
      minutes   <= minutes_next;
      hours     <= hours_next;
    end
  end

  assign time_next.hours   = hours_next;
  assign time_next.minutes = minutes_next;
  assign time_next.seconds = seconds_next;

endmodule

`default_nettype wire

@@ rtl/lspc_pulse_ctrl.sv @@
// request latch, pulse window and bridge drive with odometer
// depends on lspc_pkg
`timescale 1ns / 1ps
`default_nettype none

module lspc_pulse_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire lspc_pkg::req_beat_t req,
  input  wire logic [7:0]        pulse_ticks,
  output lspc_pkg::drive_status_t status_next
);
  import lspc_pkg::*;

  logic        pending_open, pending_open_next;
  logic        pending_close, pending_close_next;
  logic        action_open, action_open_next;
  logic        action_close, action_close_next;
  logic        opened_flag, opened_flag_next;
  logic        closed_flag, closed_flag_next;
  logic [7:0]  pulse_remaining, pulse_remaining_next;
  drive_code_t drive_state, drive_state_next;
  logic [31:0] odometer, odometer_next;
  logic        there;

  always_comb begin
    logic [7:0] rem;
    logic       ao;
    logic       ac;
    pending_open_next    = pending_open;
    pending_close_next   = pending_close;
    action_open_next     = action_open;
    action_close_next    = action_close;
    opened_flag_next     = opened_flag;
    closed_flag_next     = closed_flag;
    pulse_remaining_next = pulse_remaining;
    drive_state_next     = drive_state;
    odometer_next        = odometer;
    there                = 1'b0;
    rem                  = pulse_remaining;
    ao                   = action_open;
    ac                   = action_close;
    if (step && (req.req_type == REQ_BUTTON)) begin
      // open wins when both buttons are pressed
      if (req.buttons[BTN_OPEN_BIT]) begin
        pending_open_next = 1'b1;
        there             = opened_flag;
      end else if (req.buttons[BTN_CLOSE_BIT]) begin
        pending_close_next = 1'b1;
        there              = closed_flag;
      end
    end else if (step) begin
      if (pending_open || pending_close) begin
        rem = pulse_ticks;
        if (pending_open) begin
          ao = !opened_flag;
          ac = 1'b0;
        end else begin
          ao = 1'b0;
          ac = !closed_flag;
        end
        pending_open_next  = 1'b0;
        pending_close_next = 1'b0;
      end
      if (rem != 8'd0) begin
        pulse_remaining_next = rem - 8'd1;
        action_open_next     = ao;
        action_close_next    = ac;
        if (ao) begin
          drive_state_next = DRV_OPEN;
          opened_flag_next = 1'b1;
          closed_flag_next = 1'b0;
          odometer_next    = odometer + 32'd1;
        end else if (ac) begin
          drive_state_next = DRV_CLOSE;
          opened_flag_next = 1'b0;
          closed_flag_next = 1'b1;
          odometer_next    = odometer + 32'd1;
        end else begin
          drive_state_next = DRV_IDLE;
        end
      end else begin
        pulse_remaining_next = rem;
        drive_state_next     = DRV_IDLE;
        action_open_next     = 1'b0;
        action_close_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_open    <= 1'b0;
      pending_close   <= 1'b0;
      action_open     <= 1'b0;
      action_close    <= 1'b0;
      opened_flag     <= 1'b0;
      closed_flag     <= 1'b0;
      pulse_remaining <= '0;
      drive_state     <= DRV_IDLE;
      odometer        <= '0;
    end else begin
      pending_open    <= pending_open_next;
      pending_close   <= pending_close_next;
      action_open     <= action_open_next;
      action_close    <= action_close_next;
      opened_flag     <= opened_flag_next;
      closed_flag     <= closed_flag_next;
      pulse_remaining <= pulse_remaining_next;
      drive_state     <= drive_state_next;
      odometer        <= odometer_next;
    end
  end

  assign status_next.drive         = drive_state_next;
  assign status_next.opened        = opened_flag_next;
  assign status_next.closed        = closed_flag_next;
  assign status_next.already_there = there;
  assign status_next.odometer      = odometer_next;

  // position flags are exclusive
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(opened_flag && closed_flag))
    else $error("opened and closed flags both set");

  // a driving state always matches the position flag it sets
  a_drive_matches_flag: assert property (@(posedge clk) disable iff (rst)
    ((drive_state != DRV_OPEN) || opened_flag) &&
    ((drive_state != DRV_CLOSE) || closed_flag))
    else $error("drive state disagrees with position flags");

  // odometer only moves on a driving tick
  a_odometer_drives: assert property (@(posedge clk) disable iff (rst)
    (odometer != $past(odometer)) |-> (drive_state != DRV_IDLE))
    else $error("odometer advanced while bridge idle");

endmodule

`default_nettype wire

@@ rtl/lspc_skid.sv @@
// two-entry result buffer between the update logic and the output channel
// depends on lspc_pkg
`timescale 1ns / 1ps
`default_nettype none

module lspc_skid (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire lspc_pkg::res_beat_t push_beat,
  output logic                    not_full,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lspc_pkg::res_beat_t     out_beat
);
  import lspc_pkg::*;

  res_beat_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != 2'd0);
  assign not_full   = (count != 2'd2);
  assign out_beat   = slot[rd_ptr];
  assign count_next = count + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire
